>>> src/mwpd_pkg.sv
// mecanum wheel pid drive: shared types, codes and constants
// used by mwpd_div, mwpd_dp, mwpd_ctrl and the top level, depends on nothing
`timescale 1ns / 1ps

package mwpd_pkg;

    localparam logic [7:0] MOTOR_LOW_DEF  = 8'd0;
    localparam logic [7:0] MOTOR_HIGH_DEF = 8'd180;

    localparam int DIV_W = 50;
    localparam int MAG_W = 49;
    localparam int CNT_W = $clog2(MAG_W + 1);

    // ceil(2^34 / 500), exact floor division by 500 for values below 2^25
    localparam logic [25:0] RECIP_500 = 26'd34359739;

    typedef enum logic [2:0] {
        CFG_LIN_LIMIT = 3'd0,
        CFG_ANG_LIMIT = 3'd1,
        CFG_WHEEL_GAIN = 3'd2,
        CFG_TURN_LEVER = 3'd3,
        CFG_GAIN_P = 3'd4,
        CFG_GAIN_I = 3'd5,
        CFG_GAIN_D = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RESTART,
        OP_CLAMP,
        OP_TMUL,
        OP_TSH,
        OP_SMUL,
        OP_Z,
        OP_QMUL,
        OP_TGT,
        OP_E,
        OP_EDT,
        OP_EI,
        OP_DMUL,
        OP_DDIV,
        OP_PMUL,
        OP_PACC,
        OP_IMUL,
        OP_IACC,
        OP_WOUT,
        OP_PUB
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] wheel;
    } cmd_t;

    typedef struct packed {
        logic restart;
        logic dt_zero;
        logic div_busy;
    } status_t;

endpackage

>>> src/mwpd_if.sv
// channel interfaces of the drive: command word in, motor word out
// depends on nothing
`timescale 1ns / 1ps

interface mwpd_cmd_if;
    logic               valid;
    logic               ready;
    logic               restart;
    logic signed [15:0] cmd_vx;
    logic signed [15:0] cmd_vy;
    logic signed [15:0] cmd_wz;
    logic signed [31:0] count_rf;
    logic signed [31:0] count_rb;
    logic signed [31:0] count_lf;
    logic signed [31:0] count_lb;
    logic [15:0]        elapsed_ms;

    modport source (output valid, restart, cmd_vx, cmd_vy, cmd_wz, count_rf, count_rb,
                    count_lf, count_lb, elapsed_ms, input ready);
    modport sink (input valid, restart, cmd_vx, cmd_vy, cmd_wz, count_rf, count_rb,
                  count_lf, count_lb, elapsed_ms, output ready);
endinterface

interface mwpd_motor_if;
    logic       valid;
    logic       ready;
    logic [7:0] motor_rf;
    logic [7:0] motor_rb;
    logic [7:0] motor_lf;
    logic [7:0] motor_lb;

    modport source (output valid, motor_rf, motor_rb, motor_lf, motor_lb, input ready);
    modport sink (input valid, motor_rf, motor_rb, motor_lf, motor_lb, output ready);
endinterface

>>> src/mwpd_div.sv
// shared signed divider, one quotient bit per cycle, positive 16-bit divisor
// depends on mwpd_pkg
`timescale 1ns / 1ps

module mwpd_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [mwpd_pkg::DIV_W-1:0] dividend,
    input  logic [15:0]                       divisor,
    output logic                              busy,
    output logic signed [mwpd_pkg::DIV_W-1:0] quotient
);

    logic                        busy_reg, busy_next;
    logic [mwpd_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]                 rem_reg, rem_next;
    logic [mwpd_pkg::MAG_W-1:0]  q_reg, q_next;
    logic                        neg_reg, neg_next;
    logic [15:0]                 dsr_reg, dsr_next;
    logic signed [mwpd_pkg::DIV_W-1:0] mag_full;
    logic [16:0]                 rem_sh;

    assign mag_full = dividend[mwpd_pkg::DIV_W-1] ? -dividend : dividend;
    assign rem_sh   = {rem_reg, q_reg[mwpd_pkg::MAG_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = mwpd_pkg::CNT_W'(mwpd_pkg::MAG_W);
            rem_next  = 16'd0;
            q_next    = mag_full[mwpd_pkg::MAG_W-1:0];
            neg_next  = dividend[mwpd_pkg::DIV_W-1];
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = 16'(rem_sh - {1'b0, dsr_reg});
                q_next   = {q_reg[mwpd_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[15:0];
                q_next   = {q_reg[mwpd_pkg::MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mwpd_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

>>> src/mwpd_dp.sv
// datapath: config registers, wheel state, shared multiplier and divider
// depends on mwpd_pkg and mwpd_div
`timescale 1ns / 1ps

module mwpd_dp
#(
    parameter logic [7:0] MOTOR_LOW  = mwpd_pkg::MOTOR_LOW_DEF,
    parameter logic [7:0] MOTOR_HIGH = mwpd_pkg::MOTOR_HIGH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  restart,
    input  logic signed [15:0]    cmd_vx,
    input  logic signed [15:0]    cmd_vy,
    input  logic signed [15:0]    cmd_wz,
    input  logic signed [31:0]    count_rf,
    input  logic signed [31:0]    count_rb,
    input  logic signed [31:0]    count_lf,
    input  logic signed [31:0]    count_lb,
    input  logic [15:0]           elapsed_ms,
    input  mwpd_pkg::cmd_t        cmd,
    output mwpd_pkg::status_t     status,
    output logic [7:0]            motor_rf,
    output logic [7:0]            motor_rb,
    output logic [7:0]            motor_lf,
    output logic [7:0]            motor_lb
);

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > 51'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -51'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [7:0] mclamp(input logic signed [51:0] v);
        logic [7:0] r;
        if (v < $signed({44'd0, MOTOR_LOW}))
            r = MOTOR_LOW;
        else if (v > $signed({44'd0, MOTOR_HIGH}))
            r = MOTOR_HIGH;
        else
            r = v[7:0];
        return r;
    endfunction

    function automatic logic signed [16:0] clampsym(input logic signed [15:0] v,
                                                    input logic [14:0] lim);
        logic signed [16:0] l;
        logic signed [16:0] r;
        l = $signed({2'b00, lim});
        if (17'(v) > l)
            r = l;
        else if (17'(v) < -l)
            r = -l;
        else
            r = 17'(v);
        return r;
    endfunction

    logic [14:0] lin_limit_reg, ang_limit_reg, turn_lever_reg;
    logic [15:0] wheel_gain_reg, gain_p_reg, gain_i_reg, gain_d_reg;

    logic               restart_reg;
    logic signed [15:0] vx_reg, vy_reg, wz_reg;
    logic signed [31:0] cnt_in_reg [4];
    logic [15:0]        dt_reg;

    logic signed [31:0] last_cnt_reg [4];
    logic signed [31:0] last_err_reg [4];
    logic signed [31:0] err_sum_reg [4];

    logic signed [16:0] a_reg, b_reg, c_reg;
    logic signed [20:0] t_reg;
    logic signed [60:0] prod_reg;
    logic [24:0]        z_mag_reg;
    logic               z_neg_reg;
    logic signed [17:0] target_reg;
    logic signed [31:0] e_reg;
    logic signed [51:0] acc_reg;
    logic [7:0]         mot_w_reg [4];
    logic [7:0]         motor_reg [4];

    logic signed [26:0] ma;
    logic signed [33:0] mb;
    logic signed [60:0] mprod;
    logic signed [20:0] s_sel;
    logic signed [30:0] tp;
    logic signed [37:0] p38;
    logic signed [44:0] p100;
    logic signed [44:0] x45;
    logic signed [27:0] y28, z28, zabs;
    logic signed [32:0] dcount;
    logic [22:0]        ninety_dt;
    logic signed [34:0] num_meas;
    logic               div_start, div_busy;
    logic signed [mwpd_pkg::DIV_W-1:0] div_dividend, div_quot;
    logic signed [mwpd_pkg::DIV_W-1:0] meas;
    logic signed [48:0] ei_sum;
    logic signed [51:0] acc_tr;
    logic               dt0;
    logic [1:0]         w;

    assign w   = cmd.wheel;
    assign dt0 = (dt_reg == 16'd0);

    always_comb
    begin
        case (w)
            2'd0:    s_sel = 21'(a_reg) + 21'(b_reg) - t_reg;
            2'd1:    s_sel = 21'(a_reg) - 21'(b_reg) - t_reg;
            2'd2:    s_sel = 21'(a_reg) - 21'(b_reg) + t_reg;
            default: s_sel = 21'(a_reg) + 21'(b_reg) + t_reg;
        endcase
    end

    // shared multiplier operand selection
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            mwpd_pkg::OP_TMUL:
            begin
                ma = $signed({12'd0, turn_lever_reg});
                mb = 34'(c_reg);
            end
            mwpd_pkg::OP_SMUL:
            begin
                ma = $signed({11'd0, wheel_gain_reg});
                mb = 34'(s_sel);
            end
            mwpd_pkg::OP_QMUL:
            begin
                ma = $signed({2'd0, z_mag_reg});
                mb = $signed({8'd0, mwpd_pkg::RECIP_500});
            end
            mwpd_pkg::OP_EDT:
            begin
                ma = $signed({11'd0, dt_reg});
                mb = 34'(e_reg);
            end
            mwpd_pkg::OP_DMUL:
            begin
                ma = $signed({11'd0, gain_d_reg});
                mb = 34'(e_reg) - 34'(last_err_reg[w]);
            end
            mwpd_pkg::OP_PMUL:
            begin
                ma = $signed({11'd0, gain_p_reg});
                mb = 34'(e_reg);
            end
            mwpd_pkg::OP_IMUL:
            begin
                ma = $signed({11'd0, gain_i_reg});
                mb = 34'(err_sum_reg[w]);
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign mprod = ma * mb;

    // turn term and wheel target arithmetic
    assign tp   = prod_reg[30:0];
    assign p38  = prod_reg[37:0];
    assign p100 = (45'(p38) <<< 6) + (45'(p38) <<< 5) + (45'(p38) <<< 2);
    assign x45  = (p100 + (p100[44] ? 45'sd1048575 : 45'sd0)) >>> 20;
    assign y28  = 28'(x45) + 28'sd5000;
    assign z28  = (y28 <<< 3) + y28;
    assign zabs = z28[27] ? -z28 : z28;

    // measured speed numerator
    assign dcount    = 33'(last_cnt_reg[w]) - 33'(cnt_in_reg[w]);
    assign ninety_dt = 23'(dt_reg) * 23'd90;
    assign num_meas  = $signed({12'd0, ninety_dt}) - 35'(dcount);

    assign div_start = ((cmd.op == mwpd_pkg::OP_TGT) || (cmd.op == mwpd_pkg::OP_DDIV)) && !dt0;
    assign div_dividend = (cmd.op == mwpd_pkg::OP_TGT) ? mwpd_pkg::DIV_W'(num_meas)
                                                       : prod_reg[mwpd_pkg::DIV_W-1:0];

    mwpd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign meas   = dt0 ? mwpd_pkg::DIV_W'(90) : div_quot;
    assign ei_sum = 49'(err_sum_reg[w]) + prod_reg[48:0];
    assign acc_tr = ((acc_reg + (acc_reg[51] ? 52'sd255 : 52'sd0)) >>> 8) + 52'sd90;

    // config and wheel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_limit_reg  <= 15'd4096;
            ang_limit_reg  <= 15'd4096;
            wheel_gain_reg <= 16'd2560;
            turn_lever_reg <= 15'd1638;
            gain_p_reg     <= 16'd256;
            gain_i_reg     <= 16'd0;
            gain_d_reg     <= 16'd0;
            for (int i = 0; i < 4; i++)
            begin
                last_cnt_reg[i] <= '0;
                last_err_reg[i] <= '0;
                err_sum_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (mwpd_pkg::cfg_idx_t'(cfg_index))
                    mwpd_pkg::CFG_LIN_LIMIT:  lin_limit_reg  <= cfg_data[14:0];
                    mwpd_pkg::CFG_ANG_LIMIT:  ang_limit_reg  <= cfg_data[14:0];
                    mwpd_pkg::CFG_WHEEL_GAIN: wheel_gain_reg <= cfg_data;
                    mwpd_pkg::CFG_TURN_LEVER: turn_lever_reg <= cfg_data[14:0];
                    mwpd_pkg::CFG_GAIN_P:     gain_p_reg     <= cfg_data;
                    mwpd_pkg::CFG_GAIN_I:     gain_i_reg     <= cfg_data;
                    mwpd_pkg::CFG_GAIN_D:     gain_d_reg     <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                mwpd_pkg::OP_RESTART:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        last_cnt_reg[i] <= cnt_in_reg[i];
                        last_err_reg[i] <= '0;
                        err_sum_reg[i]  <= '0;
                    end
                end
                mwpd_pkg::OP_EI:
                begin
                    if (!dt0)
                    begin
                        err_sum_reg[w] <= sat32(51'(ei_sum));
                    end
                end
                mwpd_pkg::OP_WOUT:
                begin
                    last_err_reg[w] <= e_reg;
                    last_cnt_reg[w] <= cnt_in_reg[w];
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            mwpd_pkg::OP_LOAD:
            begin
                restart_reg   <= restart;
                vx_reg        <= cmd_vx;
                vy_reg        <= cmd_vy;
                wz_reg        <= cmd_wz;
                cnt_in_reg[0] <= count_rf;
                cnt_in_reg[1] <= count_rb;
                cnt_in_reg[2] <= count_lf;
                cnt_in_reg[3] <= count_lb;
                dt_reg        <= elapsed_ms;
            end
            mwpd_pkg::OP_RESTART:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mot_w_reg[i] <= mclamp(52'sd90);
                end
            end
            mwpd_pkg::OP_CLAMP:
            begin
                a_reg <= -clampsym(vx_reg, lin_limit_reg);
                b_reg <= -clampsym(vy_reg, lin_limit_reg);
                c_reg <= -clampsym(wz_reg, ang_limit_reg);
            end
            mwpd_pkg::OP_TSH:
            begin
                t_reg <= 21'((tp + (tp[30] ? 31'sd4095 : 31'sd0)) >>> 12);
            end
            mwpd_pkg::OP_Z:
            begin
                z_mag_reg <= zabs[24:0];
                z_neg_reg <= z28[27];
            end
            mwpd_pkg::OP_TGT:
            begin
                target_reg <= z_neg_reg ? -$signed({1'b0, prod_reg[50:34]})
                                        : $signed({1'b0, prod_reg[50:34]});
            end
            mwpd_pkg::OP_E:
            begin
                e_reg <= sat32(51'(target_reg) - 51'(meas));
            end
            mwpd_pkg::OP_PMUL:
            begin
                acc_reg <= dt0 ? 52'sd0 : 52'(div_quot);
            end
            mwpd_pkg::OP_PACC, mwpd_pkg::OP_IACC:
            begin
                acc_reg <= acc_reg + prod_reg[51:0];
            end
            mwpd_pkg::OP_WOUT:
            begin
                mot_w_reg[w] <= mclamp(acc_tr);
            end
            mwpd_pkg::OP_PUB:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    motor_reg[i] <= mot_w_reg[i];
                end
            end
            default: ;
        endcase
        case (cmd.op)
            mwpd_pkg::OP_TMUL, mwpd_pkg::OP_SMUL, mwpd_pkg::OP_QMUL, mwpd_pkg::OP_EDT,
            mwpd_pkg::OP_DMUL, mwpd_pkg::OP_PMUL, mwpd_pkg::OP_IMUL:
            begin
                prod_reg <= mprod;
            end
            default: ;
        endcase
    end

    assign status.restart  = restart_reg;
    assign status.dt_zero  = dt0;
    assign status.div_busy = div_busy;

    assign motor_rf = motor_reg[0];
    assign motor_rb = motor_reg[1];
    assign motor_lf = motor_reg[2];
    assign motor_lb = motor_reg[3];

endmodule

>>> src/mwpd_ctrl.sv
// controller: sequences the datapath through each wheel and owns the handshakes
// depends on mwpd_pkg
`timescale 1ns / 1ps

module mwpd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  mwpd_pkg::status_t status,
    output mwpd_pkg::cmd_t    cmd
);

    typedef enum logic [22:0] {
        ST_IDLE  = 23'd1 << 0,
        ST_DEC   = 23'd1 << 1,
        ST_RST   = 23'd1 << 2,
        ST_CLAMP = 23'd1 << 3,
        ST_TMUL  = 23'd1 << 4,
        ST_TSH   = 23'd1 << 5,
        ST_SMUL  = 23'd1 << 6,
        ST_Z     = 23'd1 << 7,
        ST_QMUL  = 23'd1 << 8,
        ST_TGT   = 23'd1 << 9,
        ST_MWAIT = 23'd1 << 10,
        ST_E     = 23'd1 << 11,
        ST_EDT   = 23'd1 << 12,
        ST_EI    = 23'd1 << 13,
        ST_DMUL  = 23'd1 << 14,
        ST_DDIV  = 23'd1 << 15,
        ST_DWAIT = 23'd1 << 16,
        ST_PMUL  = 23'd1 << 17,
        ST_PACC  = 23'd1 << 18,
        ST_IMUL  = 23'd1 << 19,
        ST_IACC  = 23'd1 << 20,
        ST_WOUT  = 23'd1 << 21,
        ST_PUB   = 23'd1 << 22
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] wheel_reg, wheel_next;
    logic       out_valid_reg, out_valid_next;
    logic       pub_ok;

    assign pub_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        wheel_next     = wheel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = mwpd_pkg::OP_NONE;
        cmd.wheel      = wheel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = mwpd_pkg::OP_LOAD;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                wheel_next = 2'd0;
                state_next = status.restart ? ST_RST : ST_CLAMP;
            end
            ST_RST:
            begin
                cmd.op     = mwpd_pkg::OP_RESTART;
                state_next = ST_PUB;
            end
            ST_CLAMP:
            begin
                cmd.op     = mwpd_pkg::OP_CLAMP;
                state_next = ST_TMUL;
            end
            ST_TMUL:
            begin
                cmd.op     = mwpd_pkg::OP_TMUL;
                state_next = ST_TSH;
            end
            ST_TSH:
            begin
                cmd.op     = mwpd_pkg::OP_TSH;
                state_next = ST_SMUL;
            end
            ST_SMUL:
            begin
                cmd.op     = mwpd_pkg::OP_SMUL;
                state_next = ST_Z;
            end
            ST_Z:
            begin
                cmd.op     = mwpd_pkg::OP_Z;
                state_next = ST_QMUL;
            end
            ST_QMUL:
            begin
                cmd.op     = mwpd_pkg::OP_QMUL;
                state_next = ST_TGT;
            end
            ST_TGT:
            begin
                cmd.op     = mwpd_pkg::OP_TGT;
                state_next = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_E;
                end
            end
            ST_E:
            begin
                cmd.op     = mwpd_pkg::OP_E;
                state_next = ST_EDT;
            end
            ST_EDT:
            begin
                cmd.op     = mwpd_pkg::OP_EDT;
                state_next = ST_EI;
            end
            ST_EI:
            begin
                cmd.op     = mwpd_pkg::OP_EI;
                state_next = ST_DMUL;
            end
            ST_DMUL:
            begin
                cmd.op     = mwpd_pkg::OP_DMUL;
                state_next = ST_DDIV;
            end
            ST_DDIV:
            begin
                cmd.op     = mwpd_pkg::OP_DDIV;
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                cmd.op     = mwpd_pkg::OP_PMUL;
                state_next = ST_PACC;
            end
            ST_PACC:
            begin
                cmd.op     = mwpd_pkg::OP_PACC;
                state_next = ST_IMUL;
            end
            ST_IMUL:
            begin
                cmd.op     = mwpd_pkg::OP_IMUL;
                state_next = ST_IACC;
            end
            ST_IACC:
            begin
                cmd.op     = mwpd_pkg::OP_IACC;
                state_next = ST_WOUT;
            end
            ST_WOUT:
            begin
                cmd.op     = mwpd_pkg::OP_WOUT;
                wheel_next = wheel_reg + 2'd1;
                state_next = (wheel_reg == 2'd3) ? ST_PUB : ST_SMUL;
            end
            ST_PUB:
            begin
                if (pub_ok)
                begin
                    cmd.op         = mwpd_pkg::OP_PUB;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wheel_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wheel_reg     <= wheel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> src/mecanum_wheel_pid_drive.sv
// top level of the mecanum wheel pid drive: controller, datapath, ports
// depends on mwpd_pkg, mwpd_if, mwpd_ctrl and mwpd_dp
//
//   channel    dir  handshake          word
//   cmd_ch     in   valid / ready      restart, cmd_vx/vy/wz, four counts, elapsed_ms
//   motor_ch   out  valid / ready      motor_rf, motor_rb, motor_lf, motor_lb
//   cfg        in   cfg_we             cfg_index, cfg_data
//
// one word at a time; a normal word is paced by two divisions per wheel in the single
// shared divider, each on a 49-bit magnitude; with elapsed_ms zero both divisions are skipped
// a restart word goes from the restart state straight to publish, with no wheel pass
// reset clears config to defaults and wheel state to zero; no clearing pass
// a new word is taken while the previous result waits on motor_ch
`timescale 1ns / 1ps

module mecanum_wheel_pid_drive
#(
    parameter logic [7:0] MOTOR_LOW  = mwpd_pkg::MOTOR_LOW_DEF,
    parameter logic [7:0] MOTOR_HIGH = mwpd_pkg::MOTOR_HIGH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    mwpd_cmd_if.sink      cmd_ch,
    mwpd_motor_if.source  motor_ch,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data
);

    mwpd_pkg::cmd_t    cmd;
    mwpd_pkg::status_t status;

    mwpd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_ch.valid),
        .in_ready  (cmd_ch.ready),
        .out_valid (motor_ch.valid),
        .out_ready (motor_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mwpd_dp
    #(
        .MOTOR_LOW  (MOTOR_LOW),
        .MOTOR_HIGH (MOTOR_HIGH)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .restart    (cmd_ch.restart),
        .cmd_vx     (cmd_ch.cmd_vx),
        .cmd_vy     (cmd_ch.cmd_vy),
        .cmd_wz     (cmd_ch.cmd_wz),
        .count_rf   (cmd_ch.count_rf),
        .count_rb   (cmd_ch.count_rb),
        .count_lf   (cmd_ch.count_lf),
        .count_lb   (cmd_ch.count_lb),
        .elapsed_ms (cmd_ch.elapsed_ms),
        .cmd        (cmd),
        .status     (status),
        .motor_rf   (motor_ch.motor_rf),
        .motor_rb   (motor_ch.motor_rb),
        .motor_lf   (motor_ch.motor_lf),
        .motor_lb   (motor_ch.motor_lb)
    );

endmodule
